// File: sv/bouncing_sprite_stepper_top_defines.svh
// Assertion macros for the bouncing sprite stepper
`ifndef BOUNCING_SPRITE_STEPPER_TOP_DEFINES_SVH
`define BOUNCING_SPRITE_STEPPER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bss_pkg.sv
// Shared types and constants for the bouncing sprite stepper
`default_nettype none

package bss_pkg;

    localparam int COORD_W   = 8;
    localparam int VEL_W     = 5;
    localparam int SIZE_W    = 5;
    localparam int CNT_W     = 5;
    localparam int PT_IDX_W  = 4;
    localparam int SHAPE_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_HIGH    = 3'd4;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SPEED = 1'b1;

    localparam logic [CNT_W-1:0]   RST_POINT_COUNT = 5'd12;
    localparam logic [SIZE_W-1:0]  RST_SPRITE_SIZE = 5'd4;
    localparam logic [SHAPE_W-1:0] RST_SHAPE_LOW   = 64'h1202_3121_1101_2010;
    localparam logic [SHAPE_W-1:0] RST_SHAPE_HIGH  = 64'h0000_0000_2313_3222;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MOVE_X,
        ST_MOVE_Y,
        ST_SET
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos;
        logic [VEL_W-1:0]   vel;
        logic [SIZE_W-1:0]  size;
        logic [COORD_W-1:0] screen;
    } axis_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos;
        logic [VEL_W-1:0]   vel;
    } axis_rsp_t;

endpackage

`default_nettype wire

// File: sv/bss_axis_unit.sv
// Shared axis unit: add velocity, bounce off low and high edges
`default_nettype none

module bss_axis_unit
    import bss_pkg::*;
(
    input  axis_req_t req,
    output axis_rsp_t rsp
);

    logic signed [9:0]  sum;
    logic signed [9:0]  pos_lo;
    logic signed [9:0]  span;
    logic signed [9:0]  pos_hi;
    logic [VEL_W-1:0]   vel_lo;
    logic [VEL_W-1:0]   vel_hi;

    always_comb
    begin
        sum = $signed({2'b00, req.pos}) + $signed({{5{req.vel[VEL_W-1]}}, req.vel});
        if (sum < 10'sd1)
        begin
            pos_lo = 10'sd1;
            vel_lo = VEL_W'(5'd0 - req.vel);
        end
        else
        begin
            pos_lo = sum;
            vel_lo = req.vel;
        end
        span = pos_lo + $signed({5'b00000, req.size});
        if (span > $signed({2'b00, req.screen}))
        begin
            pos_hi = $signed({2'b00, req.screen}) - $signed({5'b00000, req.size});
            vel_hi = VEL_W'(5'd0 - vel_lo);
        end
        else
        begin
            pos_hi = pos_lo;
            vel_hi = vel_lo;
        end
        rsp.pos = pos_hi[COORD_W-1:0];
        rsp.vel = vel_hi;
    end

endmodule

`default_nettype wire

// File: sv/bss_point_sel.sv
// Sprite point lookup and pixel coordinate adder
`default_nettype none

module bss_point_sel
    import bss_pkg::*;
(
    input  logic [SHAPE_W-1:0]  shape_low,
    input  logic [SHAPE_W-1:0]  shape_high,
    input  logic [PT_IDX_W-1:0] idx,
    input  logic [COORD_W-1:0]  pos_x,
    input  logic [COORD_W-1:0]  pos_y,
    output logic [COORD_W-1:0]  px,
    output logic [COORD_W-1:0]  py
);

    logic [SHAPE_W-1:0] word;
    logic [7:0]         pt_byte;

    always_comb
    begin
        word    = idx[PT_IDX_W-1] ? shape_high : shape_low;
        pt_byte = word[{idx[PT_IDX_W-2:0], 3'b000} +: 8];
        px      = pos_x + {4'b0000, pt_byte[3:0]};
        py      = pos_y + {4'b0000, pt_byte[7:4]};
    end

endmodule

`default_nettype wire

// File: sv/bouncing_sprite_stepper_top.sv
// Bouncing sprite stepper: config, sequencer, motion state, output register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | cmd, speed_x, speed_y
//  out     | output    | out_valid / out_ready| pixel_x, pixel_y, pixel_on, last
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A tick with N active points issues N clear commands, moves the x axis and
// then the y axis through the shared axis unit, then issues N set commands,
// all through a single output register.
// A stalled output holds the sequencer; in_ready is high only when idle.
// Reset is asynchronous, active low, and restores position (1,1), zero velocity
// and the default sprite.
`default_nettype none
`include "bouncing_sprite_stepper_top_defines.svh"

module bouncing_sprite_stepper_top
    import bss_pkg::*;
#(
    parameter int SCREEN_WIDTH      = 128,
    parameter int SCREEN_HEIGHT     = 64,
    parameter int MAX_SPRITE_POINTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SHAPE_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic signed [VEL_W-1:0] speed_x,
    input  logic signed [VEL_W-1:0] speed_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_W-1:0]    pixel_x,
    output logic [COORD_W-1:0]    pixel_y,
    output logic                  pixel_on,
    output logic                  last
);

    localparam logic [COORD_W-1:0] SCREEN_W = COORD_W'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0] SCREEN_H = COORD_W'(SCREEN_HEIGHT);
    localparam logic [CNT_W-1:0]   MAX_PTS  = CNT_W'(MAX_SPRITE_POINTS);

    logic [CNT_W-1:0]   point_count_reg;
    logic [SIZE_W-1:0]  sprite_width_reg;
    logic [SIZE_W-1:0]  sprite_height_reg;
    logic [SHAPE_W-1:0] shape_low_reg;
    logic [SHAPE_W-1:0] shape_high_reg;

    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_y_reg;
    logic [VEL_W-1:0]   vel_x_reg;
    logic [VEL_W-1:0]   vel_y_reg;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_sat;

    logic               out_valid_reg;
    logic [COORD_W-1:0] pixel_x_reg;
    logic [COORD_W-1:0] pixel_y_reg;
    logic               pixel_on_reg;
    logic               last_reg;

    logic               in_xfer;
    logic               slot_free;
    logic               idx_last;
    logic               load;
    logic               load_on;
    logic               load_last;

    axis_req_t          axis_req;
    axis_rsp_t          axis_rsp;
    logic [COORD_W-1:0] pt_x;
    logic [COORD_W-1:0] pt_y;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign n_sat     = (point_count_reg > MAX_PTS) ? MAX_PTS : point_count_reg;
    assign idx_last  = ((idx_reg + 5'd1) == n_reg);

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign pixel_on  = pixel_on_reg;
    assign last      = last_reg;

    always_comb
    begin
        if (state_reg == ST_MOVE_Y)
        begin
            axis_req.pos    = pos_y_reg;
            axis_req.vel    = vel_y_reg;
            axis_req.size   = sprite_height_reg;
            axis_req.screen = SCREEN_H;
        end
        else
        begin
            axis_req.pos    = pos_x_reg;
            axis_req.vel    = vel_x_reg;
            axis_req.size   = sprite_width_reg;
            axis_req.screen = SCREEN_W;
        end
    end

    bss_axis_unit u_axis (
        .req (axis_req),
        .rsp (axis_rsp)
    );

    bss_point_sel u_point (
        .shape_low  (shape_low_reg),
        .shape_high (shape_high_reg),
        .idx        (idx_reg[PT_IDX_W-1:0]),
        .pos_x      (pos_x_reg),
        .pos_y      (pos_y_reg),
        .px         (pt_x),
        .py         (pt_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (in_xfer && cmd == CMD_TICK)
            begin
                n_reg <= n_sat;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        load       = 1'b0;
        load_on    = 1'b0;
        load_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && cmd == CMD_TICK)
                begin
                    idx_next   = '0;
                    state_next = (n_sat == 5'd0) ? ST_MOVE_X : ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_MOVE_X;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            ST_MOVE_X:
            begin
                state_next = ST_MOVE_Y;
            end
            ST_MOVE_Y:
            begin
                state_next = (n_reg == 5'd0) ? ST_IDLE : ST_SET;
            end
            ST_SET:
            begin
                if (slot_free)
                begin
                    load    = 1'b1;
                    load_on = 1'b1;
                    if (idx_last)
                    begin
                        load_last  = 1'b1;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= RST_POINT_COUNT;
            sprite_width_reg  <= RST_SPRITE_SIZE;
            sprite_height_reg <= RST_SPRITE_SIZE;
            shape_low_reg     <= RST_SHAPE_LOW;
            shape_high_reg    <= RST_SHAPE_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT:   point_count_reg   <= cfg_data[CNT_W-1:0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[SIZE_W-1:0];
                REG_SHAPE_LOW:     shape_low_reg     <= cfg_data;
                REG_SHAPE_HIGH:    shape_high_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= 8'd1;
            pos_y_reg <= 8'd1;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
        else
        begin
            if (in_xfer && cmd == CMD_SPEED)
            begin
                vel_x_reg <= speed_x;
                vel_y_reg <= speed_y;
            end
            if (state_reg == ST_MOVE_X)
            begin
                pos_x_reg <= axis_rsp.pos;
                vel_x_reg <= axis_rsp.vel;
            end
            if (state_reg == ST_MOVE_Y)
            begin
                pos_y_reg <= axis_rsp.pos;
                vel_y_reg <= axis_rsp.vel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_x_reg  <= pt_x;
            pixel_y_reg  <= pt_y;
            pixel_on_reg <= load_on;
            last_reg     <= load_last;
        end
    end

    `BSS_ASSERT_SAME(a_last_is_set, out_valid_reg && last_reg, pixel_on_reg,
        "final command of a tick is not a set")
    `BSS_ASSERT_NEXT(a_tick_starts_clear,
        in_xfer && cmd == CMD_TICK && n_sat != 5'd0, state_reg == ST_CLEAR,
        "tick with points did not start clearing")
    `BSS_ASSERT_SAME(a_idx_in_range, state_reg == ST_CLEAR || state_reg == ST_SET,
        idx_reg < n_reg, "point index beyond active count")
    `BSS_ASSERT_SAME(a_last_transfer_done, out_valid_reg && out_ready && last_reg,
        state_reg != ST_SET, "sequencer still setting points at final transfer")
    `BSS_ASSERT_NEXT(a_pos_x_floor, state_reg == ST_MOVE_X, pos_x_reg != 8'd0,
        "x position left the screen after move")

endmodule

`default_nettype wire
